// ----- src/skrp_pkg.sv -----
// Shared constants, types and a helper function for the skyline rectangle packer.
package skrp_pkg;

  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS = 2048;

  localparam int ATLAS_W_W = 11;
  localparam int ATLAS_H_W = 12;
  localparam int BORDER_W = 4;
  localparam int AREA_W = 22;
  localparam int CALC_W = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_INDEX_W-1:0] CFG_ATLAS_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BORDER_TEXELS = 2'd2;

  localparam logic [ATLAS_W_W-1:0] RST_ATLAS_WIDTH = 11'd1024;
  localparam logic [ATLAS_H_W-1:0] RST_ATLAS_HEIGHT = 12'd1024;
  localparam logic [BORDER_W-1:0] RST_BORDER = 4'd0;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 72;

  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

  // Smallest power of two that is at least max(v, 1).
  function automatic logic [CALC_W:0] pow2_ceil(input logic [CALC_W-1:0] v);
    logic [CALC_W-1:0] m;
    logic [CALC_W:0] r;
    m = v - CALC_W'(1);
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    r = {1'b0, m} + (CALC_W+1)'(1);
    if (v <= CALC_W'(1)) begin
      r = (CALC_W+1)'(1);
    end
    return r;
  endfunction

endpackage

// ----- src/skrp_sky_mem.sv -----
// Skyline memory: one write port and one registered read port.
module skrp_sky_mem import skrp_pkg::*; #(
  parameter int DEPTH = DEF_MAX_COLUMNS,
  parameter int DW = $clog2(DEF_MAX_ROWS + 2)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/skrp_scan.sv -----
// Window scan sequencer: reads one skyline column per cycle and finds the lowest window.
module skrp_scan import skrp_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [$clog2(MAX_COLUMNS+2)-1:0]   wm1,
  input  logic [$clog2(MAX_COLUMNS+2)-1:0]   lim,
  input  logic [$clog2(MAX_ROWS+2)-1:0]      best_init,
  output logic                               rd_en,
  output logic [$clog2(MAX_COLUMNS)-1:0]     rd_addr,
  input  logic [$clog2(MAX_ROWS+2)-1:0]      rd_data,
  output scan_stat_t                         stat,
  output logic [$clog2(MAX_COLUMNS+2)-1:0]   best,
  output logic [$clog2(MAX_ROWS+2)-1:0]      best_s
);

  localparam int CW = $clog2(MAX_COLUMNS + 2);
  localparam int SW = $clog2(MAX_ROWS + 2);
  localparam int CI = $clog2(MAX_COLUMNS);

  logic          busy;
  logic          done;
  logic          in_win;
  logic [CW-1:0] x;
  logic [CW-1:0] idx;
  logic [CW-1:0] cnt;
  logic [SW-1:0] top;
  logic [CW-1:0] top_idx;
  logic [SW-1:0] prev;
  logic          prev_v;
  logic          best_v;

  logic          is_start;
  logic          skip;
  logic          take;
  logic [SW-1:0] t_top;
  logic [CW-1:0] t_idx;
  logic          endw;
  logic [CW-1:0] x_inc;
  logic [CW-1:0] x_jump;
  logic          term;
  logic [CW-1:0] nxt;

  always_comb begin
    is_start = !in_win;
    skip = is_start && prev_v && (rd_data == prev);
    take = is_start || (rd_data >= top);
    t_top = take ? rd_data : top;
    t_idx = take ? idx : top_idx;
    endw = is_start ? (wm1 == '0) : (cnt == '0);
    x_inc = x + CW'(1);
    x_jump = t_idx + CW'(1);
    term = 1'b0;
    nxt = idx + CW'(1);
    if (skip) begin
      term = x_inc > lim;
      nxt = x_inc;
    end else if (endw) begin
      term = x_jump > lim;
      nxt = x_jump;
    end
  end

  assign rd_en = start || (busy && !term);
  assign rd_addr = start ? '0 : nxt[CI-1:0];
  assign stat.done = done;
  assign stat.found = best_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && term;
      if (start) begin
        busy <= 1'b1;
        in_win <= 1'b0;
        x <= '0;
        idx <= '0;
        prev_v <= 1'b0;
        best_v <= 1'b0;
        best <= '0;
        best_s <= best_init;
      end else if (busy) begin
        idx <= nxt;
        if (term) begin
          busy <= 1'b0;
        end
        if (skip) begin
          x <= x_inc;
          in_win <= 1'b0;
        end else if (endw) begin
          prev <= t_top;
          prev_v <= 1'b1;
          if (best_s > t_top) begin
            best_s <= t_top;
            best <= x;
            best_v <= 1'b1;
          end
          x <= x_jump;
          in_win <= 1'b0;
        end else begin
          top <= t_top;
          top_idx <= t_idx;
          in_win <= 1'b1;
          cnt <= is_start ? (wm1 - CW'(1)) : (cnt - CW'(1));
        end
      end
    end
  end

endmodule

// ----- src/skyline_rect_packer.sv -----
// Skyline rectangle packer top level: control sequencer, packer state and stream ports.
// A place item passes prepare and check and, unless rejected, a window scan that reads skyline
// columns (the atlas width if windows do not overlap, up to width times block width), a column
// write per placed column and an area update; a clear item rewrites all MAX_COLUMNS columns.
// One item is in work at a time; a finished result waits in the output register.
// Reset is synchronous and starts a clearing pass over all MAX_COLUMNS columns before the first item.
module skyline_rect_packer import skrp_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_TDATA_W-1:0]   s_tdata,   // block_width[10:0], block_height[22:11]
  input  logic                   s_tuser,   // action
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_TDATA_W-1:0]   m_tdata,   // pos_x, pos_y, used_width, used_height, area_used
  output logic                   m_tuser    // placed
);

  localparam int CW = $clog2(MAX_COLUMNS + 2);
  localparam int SW = $clog2(MAX_ROWS + 2);
  localparam int CI = $clog2(MAX_COLUMNS);
  localparam int PW = CW + SW;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_PREP = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_EVAL = 4'd5;
  localparam logic [3:0] S_WR   = 4'd6;
  localparam logic [3:0] S_AREA = 4'd7;
  localparam logic [3:0] S_RESP = 4'd8;

  localparam logic [CALC_W-1:0] MAXC16 = CALC_W'(MAX_COLUMNS);
  localparam logic [CALC_W-1:0] MAXR16 = CALC_W'(MAX_ROWS);
  localparam logic [CW-1:0] RST_FLW =
      CW'((int'(RST_ATLAS_WIDTH) < MAX_COLUMNS ? int'(RST_ATLAS_WIDTH) : MAX_COLUMNS) + 1);
  localparam logic [SW-1:0] RST_FLH =
      SW'((int'(RST_ATLAS_HEIGHT) < MAX_ROWS ? int'(RST_ATLAS_HEIGHT) : MAX_ROWS) + 1);

  logic [3:0]           state;
  logic [ATLAS_W_W-1:0] atlas_width;
  logic [ATLAS_H_W-1:0] atlas_height;
  logic [BORDER_W-1:0]  border_texels;

  logic [CW-1:0]        flw;
  logic [SW-1:0]        flh;
  logic                 ext_any;
  logic [CW-1:0]        ext_w;
  logic [SW-1:0]        ext_h;
  logic [AREA_W-1:0]    area_total;
  logic [ATLAS_W_W-1:0] used_w;
  logic [ATLAS_H_W-1:0] used_h;

  logic                 clr_resp;
  logic [CI-1:0]        clr_idx;
  logic [ATLAS_W_W-1:0] bw;
  logic [ATLAS_H_W-1:0] bh;
  logic [CW-1:0]        weff;
  logic [SW-1:0]        heff;
  logic [CW-1:0]        w;
  logic [SW-1:0]        h;
  logic [CI-1:0]        wr_ptr;
  logic [CW-1:0]        wr_rem;
  logic [SW-1:0]        new_top;
  logic [PW-1:0]        prod;
  logic                 res_placed;
  logic [ATLAS_W_W-1:0] res_x;
  logic [ATLAS_H_W-1:0] res_y;

  logic [CALC_W-1:0]    aw16;
  logic [CALC_W-1:0]    ah16;
  logic [CALC_W-1:0]    pad_w;
  logic [CALC_W-1:0]    pad_h;
  logic [CALC_W-1:0]    weff16;
  logic [CALC_W-1:0]    heff16;
  logic [CALC_W-1:0]    top_chk;
  logic [CALC_W-1:0]    ext_w_new;
  logic [CALC_W-1:0]    ext_h_new;
  logic [CALC_W:0]      pw2_w;
  logic [CALC_W:0]      pw2_h;
  logic [PW:0]          area_sum;

  logic                 accept;
  logic                 scan_start;
  logic                 reject_now;
  logic                 mem_we;
  logic [CI-1:0]        mem_waddr;
  logic [SW-1:0]        mem_wdata;
  logic                 mem_re;
  logic [CI-1:0]        mem_raddr;
  logic [SW-1:0]        mem_rdata;
  scan_stat_t           stat;
  logic [CW-1:0]        best;
  logic [SW-1:0]        best_s;

  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid && s_tready;

  always_comb begin
    aw16 = CALC_W'(atlas_width);
    ah16 = CALC_W'(atlas_height);
    weff16 = (aw16 < MAXC16) ? aw16 : MAXC16;
    heff16 = (ah16 < MAXR16) ? ah16 : MAXR16;
    pad_w = CALC_W'(bw) + CALC_W'({border_texels, 1'b0});
    pad_h = CALC_W'(bh) + CALC_W'({border_texels, 1'b0});
    if (pad_w > weff16) begin
      pad_w = weff16;
    end
    if (pad_h > heff16) begin
      pad_h = heff16;
    end
    reject_now = (w == '0) || ((w >= flw) && (h >= flh));
    scan_start = (state == S_CHK) && !reject_now;
    top_chk = CALC_W'(best_s) + CALC_W'(h) + CALC_W'(1);
    ext_w_new = CALC_W'(best) + CALC_W'(w);
    ext_h_new = CALC_W'(best_s) + CALC_W'(h);
    pw2_w = pow2_ceil(CALC_W'(ext_w));
    pw2_h = pow2_ceil(CALC_W'(ext_h));
    area_sum = (PW+1)'(area_total) + (PW+1)'(prod);
    mem_we = (state == S_CLR) || (state == S_WR);
    mem_waddr = (state == S_CLR) ? clr_idx : wr_ptr;
    mem_wdata = (state == S_CLR) ? '0 : new_top;
  end

  skrp_sky_mem #(
    .DEPTH (MAX_COLUMNS),
    .DW    (SW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  skrp_scan #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .wm1       (w - CW'(1)),
    .lim       (weff - w),
    .best_init (heff + SW'(1)),
    .rd_en     (mem_re),
    .rd_addr   (mem_raddr),
    .rd_data   (mem_rdata),
    .stat      (stat),
    .best      (best),
    .best_s    (best_s)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width <= RST_ATLAS_WIDTH;
      atlas_height <= RST_ATLAS_HEIGHT;
      border_texels <= RST_BORDER;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATLAS_WIDTH: atlas_width <= cfg_data[ATLAS_W_W-1:0];
        CFG_ATLAS_HEIGHT: atlas_height <= cfg_data[ATLAS_H_W-1:0];
        CFG_BORDER_TEXELS: border_texels <= cfg_data[BORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_idx <= '0;
      clr_resp <= 1'b0;
      flw <= RST_FLW;
      flh <= RST_FLH;
      ext_any <= 1'b0;
      ext_w <= '0;
      ext_h <= '0;
      area_total <= '0;
      used_w <= '0;
      used_h <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_RESP)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + CI'(1);
          if (clr_idx == CI'(MAX_COLUMNS - 1)) begin
            state <= clr_resp ? S_RESP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            bw <= s_tdata[ATLAS_W_W-1:0];
            bh <= s_tdata[ATLAS_W_W +: ATLAS_H_W];
            res_placed <= 1'b0;
            res_x <= '0;
            res_y <= '0;
            if (s_tuser) begin
              flw <= CW'(weff16) + CW'(1);
              flh <= SW'(heff16) + SW'(1);
              ext_any <= 1'b0;
              ext_w <= '0;
              ext_h <= '0;
              area_total <= '0;
              used_w <= '0;
              used_h <= '0;
              clr_idx <= '0;
              clr_resp <= 1'b1;
              state <= S_CLR;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          weff <= CW'(weff16);
          heff <= SW'(heff16);
          w <= CW'(pad_w);
          h <= SW'(pad_h);
          state <= S_CHK;
        end
        S_CHK: begin
          state <= reject_now ? S_RESP : S_SCAN;
        end
        S_SCAN: begin
          if (stat.done) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!stat.found || (top_chk >= CALC_W'(heff))) begin
            if ((w <= flw) && (h <= flh)) begin
              flw <= w;
              flh <= h;
            end
            state <= S_RESP;
          end else begin
            ext_any <= 1'b1;
            if (ext_w_new > CALC_W'(ext_w)) begin
              ext_w <= CW'(ext_w_new);
            end
            if (ext_h_new > CALC_W'(ext_h)) begin
              ext_h <= SW'(ext_h_new);
            end
            new_top <= SW'(ext_h_new);
            prod <= PW'(w) * PW'(h);
            wr_ptr <= best[CI-1:0];
            wr_rem <= w;
            res_placed <= 1'b1;
            res_x <= ATLAS_W_W'(CALC_W'(best) + CALC_W'(border_texels));
            res_y <= ATLAS_H_W'(CALC_W'(best_s) + CALC_W'(border_texels));
            state <= S_WR;
          end
        end
        S_WR: begin
          wr_ptr <= wr_ptr + CI'(1);
          wr_rem <= wr_rem - CW'(1);
          if (wr_rem == CW'(1)) begin
            state <= S_AREA;
          end
        end
        S_AREA: begin
          if (area_sum > (PW+1)'(AREA_MAX)) begin
            area_total <= AREA_MAX;
          end else begin
            area_total <= AREA_W'(area_sum);
          end
          used_w <= ext_any ? pw2_w[ATLAS_W_W-1:0] : '0;
          used_h <= ext_any ? pw2_h[ATLAS_H_W-1:0] : '0;
          state <= S_RESP;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser <= res_placed;
            m_tdata <= {4'd0, area_total, used_h, used_w, res_y, res_x};
            clr_resp <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/skyline_rect_packer_tb.sv -----
// Self-checking testbench for the skyline rectangle packer with a built-in packing predictor.
module skyline_rect_packer_tb import skrp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_PLACE = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;
  localparam int COLUMNS = DEF_MAX_COLUMNS;
  localparam int ROWS = DEF_MAX_ROWS;
  localparam int IDLE_PCT = 18;

  typedef struct packed {
    logic                 placed;
    logic [ATLAS_W_W-1:0] pos_x;
    logic [ATLAS_H_W-1:0] pos_y;
    logic [ATLAS_W_W-1:0] used_width;
    logic [ATLAS_H_W-1:0] used_height;
    logic [AREA_W-1:0]    area_used;
  } placement_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_ATLAS_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;   // block_width[10:0], block_height[22:11]
  logic                   s_tuser = 1'b0; // action
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // pos_x[10:0], pos_y[22:11], used_width[33:23], used_height[45:34], area_used[67:46]
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tuser;        // placed

  int skyline_top [COLUMNS];
  int fail_w;
  int fail_h;
  int extent_w;
  int extent_h;
  int area_sum;
  int atlas_w_reg;
  int atlas_h_reg;
  int border_reg;
  placement_t placements_due [$];
  int mismatches = 0;
  bit steady_flow = 1'b0;
  int ready_hold = 0;

  skyline_rect_packer dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int usable_width();
    return (atlas_w_reg < COLUMNS) ? atlas_w_reg : COLUMNS;
  endfunction

  function automatic int usable_height();
    return (atlas_h_reg < ROWS) ? atlas_h_reg : ROWS;
  endfunction

  function automatic void clear_packer();
    foreach (skyline_top[i]) skyline_top[i] = -1;
    fail_w = usable_width() + 1;
    fail_h = usable_height() + 1;
    extent_w = -1;
    extent_h = -1;
    area_sum = 0;
  endfunction

  function automatic int pow2_extent(int v);
    int p;
    if (v < 0) return 0;
    p = 1;
    while (p < v) p = p << 1;
    return p;
  endfunction

  function automatic placement_t pack_predict(logic action, int bw, int bh);
    placement_t res;
    int width_lim, height_lim, w, h, best, best_y, prev, x, top, top_idx, y;
    res = '0;
    if (action == ACT_CLEAR) begin
      clear_packer();
    end else begin
      width_lim = usable_width();
      height_lim = usable_height();
      w = bw + 2 * border_reg;
      h = bh + 2 * border_reg;
      if (w > width_lim) w = width_lim;
      if (h > height_lim) h = height_lim;
      if (w > 0 && !(w >= fail_w && h >= fail_h)) begin
        best = -1;
        best_y = height_lim;
        prev = -2;
        x = 0;
        while (x <= width_lim - w) begin
          if (skyline_top[x] == prev) begin
            x++;
          end else begin
            top = -1;
            top_idx = x;
            for (int i = x; i < x + w; i++) begin
              if (skyline_top[i] >= top) begin
                top = skyline_top[i];
                top_idx = i;
              end
            end
            prev = skyline_top[top_idx];
            if (best_y > prev) begin
              best_y = prev;
              best = x;
            end
            x = top_idx + 1;
          end
        end
        y = best_y + 1;
        if (best < 0 || y + h >= height_lim - 1) begin
          if (w <= fail_w && h <= fail_h) begin
            fail_w = w;
            fail_h = h;
          end
        end else begin
          if (y + h > extent_h) extent_h = y + h;
          if (best + w > extent_w) extent_w = best + w;
          for (int i = best; i < best + w; i++) skyline_top[i] = best_y + h;
          area_sum += w * h;
          if (area_sum > int'(AREA_MAX)) area_sum = int'(AREA_MAX);
          res.placed = 1'b1;
          res.pos_x = ATLAS_W_W'(best + border_reg);
          res.pos_y = ATLAS_H_W'(y + border_reg);
        end
      end
    end
    res.used_width = ATLAS_W_W'(pow2_extent(extent_w));
    res.used_height = ATLAS_H_W'(pow2_extent(extent_h));
    res.area_used = AREA_W'(area_sum);
    return res;
  endfunction

  function automatic void match_field(string name, int want, int got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(input logic action, input int bw, input int bh);
    bit taken;
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= action;
    s_tdata <= S_TDATA_W'({bh[ATLAS_H_W-1:0], bw[ATLAS_W_W-1:0]});
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    placements_due.push_back(pack_predict(action, bw, bh));
  endtask

  task automatic send_random_item(input int span_w, input int span_h, input int wide_pct);
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) begin
      send_item(ACT_CLEAR, $urandom_range(1024), $urandom_range(2048));
    end else if (pick < 4 + wide_pct) begin
      send_item(ACT_PLACE, $urandom_range(1024), $urandom_range(2048));
    end else begin
      send_item(ACT_PLACE, $urandom_range(span_w), $urandom_range(span_h));
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_config(input int aw, input int ah, input int border);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ATLAS_WIDTH;
    cfg_data <= CFG_DATA_W'(aw);
    @(posedge clk);
    atlas_w_reg = aw & 'h7FF;
    cfg_index <= CFG_ATLAS_HEIGHT;
    cfg_data <= CFG_DATA_W'(ah);
    @(posedge clk);
    atlas_h_reg = ah & 'hFFF;
    cfg_index <= CFG_BORDER_TEXELS;
    cfg_data <= CFG_DATA_W'(border);
    @(posedge clk);
    border_reg = border & 'hF;
    cfg_we <= 1'b0;
  endtask

  task automatic test_default_atlas();
    send_item(ACT_PLACE, 0, 5);
    send_item(ACT_PLACE, 1024, 16);
    send_item(ACT_PLACE, 1, 1);
    send_item(ACT_PLACE, 1024, 2048);
    send_item(ACT_PLACE, 1024, 2048);
    send_item(ACT_PLACE, 1000, 1000);
    send_item(ACT_CLEAR, 1024, 2048);
    send_item(ACT_PLACE, 1024, 1007);
    drain();
  endtask

  task automatic test_border_clamp();
    write_config(16, 2048, 15);
    send_item(ACT_CLEAR, 0, 0);
    send_item(ACT_PLACE, 0, 0);
    send_item(ACT_PLACE, 1024, 2048);
    send_item(ACT_PLACE, 1, 1);
    drain();
    write_config(16, 2048, 0);
    send_item(ACT_PLACE, 0, 7);
    send_item(ACT_PLACE, 5, 3);
    drain();
  endtask

  task automatic test_window_scan();
    write_config(32, 256, 0);
    send_item(ACT_CLEAR, 0, 0);
    send_item(ACT_PLACE, 4, 40);
    send_item(ACT_PLACE, 4, 30);
    send_item(ACT_PLACE, 4, 20);
    send_item(ACT_PLACE, 4, 10);
    send_item(ACT_PLACE, 8, 5);
    send_item(ACT_PLACE, 3, 5);
    send_item(ACT_PLACE, 12, 1);
    send_item(ACT_PLACE, 32, 1);
    drain();
  endtask

  task automatic test_stale_fail_limit();
    write_config(32, 32, 0);
    send_item(ACT_CLEAR, 0, 0);
    send_item(ACT_PLACE, 32, 40);
    drain();
    write_config(32, 1024, 0);
    send_item(ACT_PLACE, 32, 40);
    send_item(ACT_CLEAR, 0, 0);
    send_item(ACT_PLACE, 32, 40);
    drain();
  endtask

  task automatic test_backpressure();
    write_config(64, 2048, 1);
    send_item(ACT_CLEAR, 0, 0);
    steady_flow = 1'b1;
    ready_hold = 300;
    repeat (20) send_random_item(20, 100, 5);
    steady_flow = 1'b0;
    drain();
  endtask

  task automatic test_random_phases();
    int aw, ah, border, span_w, span_h, wide_pct;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: begin
          aw = 1;
          ah = 1;
          border = 15;
        end
        1: begin
          aw = 1024;
          ah = 2048;
          border = 0;
        end
        2: begin
          aw = 16;
          ah = 2048;
          border = 0;
        end
        default: begin
          aw = $urandom_range(16, 128);
          ah = ($urandom_range(3) == 0) ? 2048 : $urandom_range(16, 512);
          border = $urandom_range(15);
        end
      endcase
      span_w = (aw >= 1024) ? 16 : ((aw / 3 > 1) ? aw / 3 : 1);
      span_h = (ah / 6 > 1) ? ah / 6 : 1;
      wide_pct = (aw >= 1024) ? 3 : 8;
      steady_flow = (phase == 6);
      write_config(aw, ah, border);
      if ($urandom_range(3) != 0) begin
        send_item(ACT_CLEAR, $urandom_range(1024), $urandom_range(2048));
      end
      repeat (45) send_random_item(span_w, span_h, wide_pct);
      drain();
    end
    steady_flow = 1'b0;
  endtask

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : result_check
    placement_t want;
    forever begin
      @(negedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (placements_due.size() == 0) begin
          $error("result arrived with no item outstanding");
          mismatches++;
        end else begin
          want = placements_due.pop_front();
          match_field("placed", want.placed, m_tuser);
          match_field("pos_x", want.pos_x, m_tdata[10:0]);
          match_field("pos_y", want.pos_y, m_tdata[22:11]);
          match_field("used_width", want.used_width, m_tdata[33:23]);
          match_field("used_height", want.used_height, m_tdata[45:34]);
          match_field("area_used", want.area_used, m_tdata[67:46]);
        end
      end
    end
  end

  initial begin
    #1s;
    $display("simulation failed");
    $finish;
  end

  initial begin
    atlas_w_reg = RST_ATLAS_WIDTH;
    atlas_h_reg = RST_ATLAS_HEIGHT;
    border_reg = RST_BORDER;
    clear_packer();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_default_atlas();
    test_border_clamp();
    test_window_scan();
    test_stale_fail_limit();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
